// File: hdl/assert_macros.svh
// Assertion macros used by the verification checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/u8cpd_pkg.sv
// Package with the types and constants of the UTF-8 code point decoder.
`default_nettype none
package u8cpd_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 31;
    localparam int LEN_W  = 3;

    localparam logic [CP_W-1:0]  REPLACEMENT_CHAR = 31'd63;
    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;

    // Classification of one byte taken as a lead byte.
    typedef struct packed {
        logic              valid;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] payload;
    } lead_info_t;

endpackage
`default_nettype wire

// File: hdl/u8cpd_lead_decode.sv
// Lead byte classifier: sequence length and payload bits of a lead byte.
`default_nettype none
module u8cpd_lead_decode (
    input  wire logic [u8cpd_pkg::BYTE_W-1:0] lead_byte,
    output u8cpd_pkg::lead_info_t             info
);

    always_comb
    begin
        info.valid   = 1'b1;
        info.length  = u8cpd_pkg::LEN_ONE;
        info.payload = lead_byte;
        unique casez (lead_byte)
            8'b0???????:
            begin
                info.length  = 3'd1;
                info.payload = lead_byte;
            end
            8'b110?????:
            begin
                info.length  = 3'd2;
                info.payload = lead_byte & 8'h1F;
            end
            8'b1110????:
            begin
                info.length  = 3'd3;
                info.payload = lead_byte & 8'h0F;
            end
            8'b11110???:
            begin
                info.length  = 3'd4;
                info.payload = lead_byte & 8'h07;
            end
            8'b111110??:
            begin
                info.length  = 3'd5;
                info.payload = lead_byte & 8'h03;
            end
            8'b1111110?:
            begin
                info.length  = 3'd6;
                info.payload = lead_byte & 8'h01;
            end
            default:
            begin
                // Continuation pattern or 0xFE/0xFF seen as a lead byte.
                info.valid   = 1'b0;
                info.length  = u8cpd_pkg::LEN_NONE;
                info.payload = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/utf8_code_point_decoder_unit.sv
// Top level of the byte-serial UTF-8 code point decoder (one to six byte form).
// A completing byte goes through the input register, then the result register.
// Throughput: one byte per cycle while the result side takes every result.
// The rate is set by the single decode pass between the input and result registers.
// Reset (rst_n low, asynchronous) empties both registers and drops any pending sequence.
`default_nettype none
module utf8_code_point_decoder_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [u8cpd_pkg::BYTE_W-1:0] byte_in,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [u8cpd_pkg::CP_W-1:0]        code_point,
    output logic [u8cpd_pkg::LEN_W-1:0]       seq_length
);

    // Input register: holds one accepted byte until the decode pass can run.
    logic                         in_valid_reg;
    logic [u8cpd_pkg::BYTE_W-1:0] byte_reg;

    // Sequence state carried from byte to byte.
    logic [u8cpd_pkg::LEN_W-1:0] bytes_left_reg, bytes_left_next;
    logic [u8cpd_pkg::CP_W-1:0]  accum_reg, accum_next;
    logic [u8cpd_pkg::LEN_W-1:0] cur_length_reg, cur_length_next;

    // Result register.
    logic                         out_valid_reg;
    logic [u8cpd_pkg::CP_W-1:0]  code_point_reg, code_point_next;
    logic [u8cpd_pkg::LEN_W-1:0] seq_length_reg, seq_length_next;
    logic                         emit_next;

    logic                  advance;
    u8cpd_pkg::lead_info_t lead;

    // The decode pass runs when a byte is held and the result slot is free or
    // is being emptied in this cycle. A byte that yields no result still waits
    // for that, which keeps the control simple and costs nothing at full rate.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    u8cpd_lead_decode u_lead (
        .lead_byte (byte_reg),
        .info      (lead)
    );

    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        accum_next      = accum_reg;
        cur_length_next = cur_length_reg;
        code_point_next = code_point_reg;
        seq_length_next = seq_length_reg;
        emit_next       = 1'b0;

        if (bytes_left_reg != '0)
        begin
            // Following byte: its low six bits are appended whatever its top bits are.
            accum_next      = {accum_reg[u8cpd_pkg::CP_W-7:0], byte_reg[5:0]};
            bytes_left_next = bytes_left_reg - 3'd1;
            if (bytes_left_reg == 3'd1)
            begin
                emit_next       = 1'b1;
                code_point_next = {accum_reg[u8cpd_pkg::CP_W-7:0], byte_reg[5:0]};
                seq_length_next = cur_length_reg;
            end
        end
        else if (!lead.valid)
        begin
            // Invalid lead byte is replaced by a question mark of length one.
            emit_next       = 1'b1;
            code_point_next = u8cpd_pkg::REPLACEMENT_CHAR;
            seq_length_next = u8cpd_pkg::LEN_ONE;
        end
        else if (lead.length == u8cpd_pkg::LEN_ONE)
        begin
            emit_next       = 1'b1;
            code_point_next = {{(u8cpd_pkg::CP_W-u8cpd_pkg::BYTE_W){1'b0}}, byte_reg};
            seq_length_next = u8cpd_pkg::LEN_ONE;
        end
        else
        begin
            // Multi-byte lead: start the accumulator with the lead's payload bits.
            accum_next      = {{(u8cpd_pkg::CP_W-u8cpd_pkg::BYTE_W){1'b0}}, lead.payload};
            cur_length_next = lead.length;
            bytes_left_next = lead.length - 3'd1;
        end
    end

    // Control and sequence state, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            bytes_left_reg <= '0;
            accum_reg      <= '0;
            cur_length_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                bytes_left_reg <= bytes_left_next;
                accum_reg      <= accum_next;
                cur_length_reg <= cur_length_next;
                out_valid_reg  <= emit_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= byte_in;
        end
        if (advance && emit_next)
        begin
            code_point_reg <= code_point_next;
            seq_length_reg <= seq_length_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign code_point = code_point_reg;
    assign seq_length = seq_length_reg;

endmodule
`default_nettype wire

// File: hdl/u8cpd_checker.sv
// Port-level checker for the UTF-8 code point decoder, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module u8cpd_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [u8cpd_pkg::CP_W-1:0]   code_point,
    input wire logic [u8cpd_pkg::LEN_W-1:0]  seq_length
);

    logic                                           len_legal;
    logic                                           len_one;
    logic                                           len_two;
    logic                                           out_stall;
    logic [u8cpd_pkg::CP_W+u8cpd_pkg::LEN_W-1:0]    result_word;

    assign len_legal   = (seq_length != 3'd0) && (seq_length != 3'd7);
    assign len_one     = (seq_length == 3'd1);
    assign len_two     = (seq_length == 3'd2);
    assign out_stall   = out_valid && !out_ready;
    assign result_word = {code_point, seq_length};

    `ASSERT_IMPLIES(a_len_range, clk, rst_n, out_valid, len_legal)

    `ASSERT_IMPLIES(a_single_byte_ascii, clk, rst_n, out_valid && len_one, code_point[30:7] == '0)

    `ASSERT_IMPLIES(a_two_byte_width, clk, rst_n, out_valid && len_two, code_point[30:11] == '0)

    `ASSERT_IMPLIES(a_input_stall_cause, clk, rst_n, !in_ready, out_stall)

    `ASSERT_NEXT(a_result_held, clk, rst_n, out_stall, out_valid && $stable(result_word))

endmodule

bind utf8_code_point_decoder_unit u8cpd_checker u_u8cpd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point),
    .seq_length (seq_length)
);
`default_nettype wire
